// File: rtl/scale_rotate_translate_point_top_assert.svh
// Assertion macros used by the checker module of the point transform block.
`ifndef SCALE_ROTATE_TRANSLATE_POINT_TOP_ASSERT_SVH
`define SCALE_ROTATE_TRANSLATE_POINT_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define SRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs during reset.
`define SRT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srt_pkg.sv
// Shared constants and types of the scale, rotate and translate point block.
package srt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int Q_W             = 16;
    localparam int Q_FRAC          = 14;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC      = 8;
    localparam int SCALE_PACKED_W  = 3 * SCALE_W;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_ADDR_W      = 3;
    localparam int NUM_STAGES      = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_W   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_I   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_J   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_K   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 3'd7;

    localparam logic [Q_W-1:0]            QUAT_W_RESET = 16'h4000;
    localparam logic [SCALE_PACKED_W-1:0] SCALE_RESET  = 48'h0100_0100_0100;

    typedef struct packed {
        logic signed [Q_W-1:0]     qw;
        logic signed [Q_W-1:0]     qi;
        logic signed [Q_W-1:0]     qj;
        logic signed [Q_W-1:0]     qk;
        logic [SCALE_PACKED_W-1:0] scale;
    } xform_cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

// File: rtl/srt_datapath.sv
// Six-stage arithmetic pipeline: scale, quaternion rotate, translate, saturate.
module srt_datapath #(
    parameter int COORD_WIDTH = srt_pkg::COORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  srt_pkg::pipe_ctl_t          ctl,
    input  srt_pkg::xform_cfg_t         xcfg,
    input  logic [2:0][COORD_WIDTH-1:0] offset,
    input  logic                        in_mode,
    input  logic [2:0][COORD_WIDTH-1:0] in_coord,
    output logic [2:0][COORD_WIDTH-1:0] out_coord,
    output logic                        out_sat
);
    import srt_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int SP_W = CW + SCALE_W;      // coord * scale
    localparam int S_W  = SP_W - SCALE_FRAC; // scaled point
    localparam int P1_W = S_W + Q_W;         // u * s
    localparam int M1_W = P1_W - Q_FRAC;
    localparam int T_W  = M1_W + 2;          // t = 2 * (diff)
    localparam int P2_W = T_W + Q_W;         // q * t
    localparam int M2_W = P2_W - Q_FRAC;
    localparam int R_W  = CW + 18;

    localparam logic signed [SP_W-1:0] SC_RND = SP_W'(2 ** (SCALE_FRAC - 1));
    localparam logic signed [P1_W-1:0] P1_RND = P1_W'(2 ** (Q_FRAC - 1));
    localparam logic signed [P2_W-1:0] P2_RND = P2_W'(2 ** (Q_FRAC - 1));

    logic signed [Q_W-1:0]     u   [3];
    logic signed [SCALE_W-1:0] scl [3];

    logic signed [SP_W-1:0] ps_reg  [3];
    logic signed [S_W-1:0]  s_val   [3];
    logic signed [S_W-1:0]  s1_reg  [3];
    logic signed [P1_W-1:0] pa1_reg [3];
    logic signed [P1_W-1:0] pb1_reg [3];
    logic signed [S_W-1:0]  s2_reg  [3];
    logic signed [T_W-1:0]  t2_reg  [3];
    logic signed [S_W-1:0]  s3_reg  [3];
    logic signed [P2_W-1:0] pw3_reg [3];
    logic signed [P2_W-1:0] pa3_reg [3];
    logic signed [P2_W-1:0] pb3_reg [3];
    logic signed [R_W-1:0]  r4_reg  [3];
    logic [3:0]             mode_reg;
    logic [2:0]             sat_axis;
    logic [2:0][CW-1:0]     out_coord_reg;
    logic                   sat_reg;

    assign u[0] = xcfg.qi;
    assign u[1] = xcfg.qj;
    assign u[2] = xcfg.qk;

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) mode_reg[0] <= in_mode;
        if (ctl.en[1]) mode_reg[1] <= mode_reg[0];
        if (ctl.en[2]) mode_reg[2] <= mode_reg[1];
        if (ctl.en[3]) mode_reg[3] <= mode_reg[2];
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int B = (a + 1) % 3;
        localparam int C = (a + 2) % 3;

        logic signed [SP_W-1:0] ps_rnd;
        logic signed [P1_W-1:0] pa1_rnd, pb1_rnd;
        logic signed [M1_W-1:0] ma1, mb1;
        logic signed [M1_W:0]   mdiff;
        logic signed [P2_W-1:0] pw3_rnd, pa3_rnd, pb3_rnd;
        logic signed [M2_W-1:0] mw2, ma2, mb2;
        logic signed [R_W-1:0]  off_term, r_val;
        logic [R_W-CW:0]        hi;
        logic                   ovf_pos, ovf_neg;
        logic [CW-1:0]          clip_val;

        assign scl[a] = xcfg.scale[SCALE_W*a +: SCALE_W];

        // stage 0: per-axis scale product
        always_ff @(posedge aclk) begin
            if (ctl.en[0]) ps_reg[a] <= SP_W'($signed(in_coord[a])) * SP_W'(scl[a]);
        end

        // stage 1: round scale, first cross-product terms
        assign ps_rnd   = ps_reg[a] + SC_RND;
        assign s_val[a] = ps_rnd[SP_W-1:SCALE_FRAC];

        always_ff @(posedge aclk) begin
            if (ctl.en[1]) begin
                s1_reg[a]  <= s_val[a];
                pa1_reg[a] <= P1_W'(u[B]) * P1_W'(s_val[C]);
                pb1_reg[a] <= P1_W'(u[C]) * P1_W'(s_val[B]);
            end
        end

        // stage 2: round each product half up, t = 2 * (u x s)
        assign pa1_rnd = pa1_reg[a] + P1_RND;
        assign pb1_rnd = pb1_reg[a] + P1_RND;
        assign ma1     = pa1_rnd[P1_W-1:Q_FRAC];
        assign mb1     = pb1_rnd[P1_W-1:Q_FRAC];
        assign mdiff   = (M1_W+1)'(ma1) - (M1_W+1)'(mb1);

        always_ff @(posedge aclk) begin
            if (ctl.en[2]) begin
                s2_reg[a] <= s1_reg[a];
                t2_reg[a] <= {mdiff, 1'b0};
            end
        end

        // stage 3: w*t and u x t products
        always_ff @(posedge aclk) begin
            if (ctl.en[3]) begin
                s3_reg[a]  <= s2_reg[a];
                pw3_reg[a] <= P2_W'(xcfg.qw) * P2_W'(t2_reg[a]);
                pa3_reg[a] <= P2_W'(u[B]) * P2_W'(t2_reg[C]);
                pb3_reg[a] <= P2_W'(u[C]) * P2_W'(t2_reg[B]);
            end
        end

        // stage 4: round, sum, translate in point mode
        assign pw3_rnd  = pw3_reg[a] + P2_RND;
        assign pa3_rnd  = pa3_reg[a] + P2_RND;
        assign pb3_rnd  = pb3_reg[a] + P2_RND;
        assign mw2      = pw3_rnd[P2_W-1:Q_FRAC];
        assign ma2      = pa3_rnd[P2_W-1:Q_FRAC];
        assign mb2      = pb3_rnd[P2_W-1:Q_FRAC];
        assign off_term = mode_reg[3] ? '0 : R_W'($signed(offset[a]));
        assign r_val    = R_W'(s3_reg[a]) + R_W'(mw2) + R_W'(ma2) - R_W'(mb2) + off_term;

        always_ff @(posedge aclk) begin
            if (ctl.en[4]) r4_reg[a] <= r_val;
        end

        // stage 5: clip to the coordinate range
        assign hi       = r4_reg[a][R_W-1:CW-1];
        assign ovf_pos  = !r4_reg[a][R_W-1] && (|hi);
        assign ovf_neg  = r4_reg[a][R_W-1] && !(&hi);
        assign sat_axis[a] = ovf_pos || ovf_neg;

        always_comb begin
            priority if (ovf_pos) begin
                clip_val = {1'b0, {(CW-1){1'b1}}};
            end else if (ovf_neg) begin
                clip_val = {1'b1, {(CW-1){1'b0}}};
            end else begin
                clip_val = r4_reg[a][CW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en[5]) out_coord_reg[a] <= clip_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[5]) sat_reg <= |sat_axis;
    end

    assign out_coord = out_coord_reg;
    assign out_sat   = sat_reg;

endmodule

// File: rtl/scale_rotate_translate_point_top.sv
// Top level of the scale, rotate and translate point block.
//
//  channel  | dir | tdata (low bit up)      | tuser
//  ---------+-----+-------------------------+-----------
//  s_       | in  | in_x, in_y, in_z        | mode
//  m_       | out | out_x, out_y, out_z     | saturated
//  cfg_     | in  | write index, write data | -
//
// One item per clock sustained while m_tready is high; items pass through the
// six register stages (scale mult, two rotate mult levels with their rounding,
// sum, clip), at most one multiplier deep each.
// Each stage takes a new item whenever it is empty or its successor moves,
// so a stalled m_ side backs up stage by stage and bubbles are absorbed.
// Synchronous active-low reset empties the pipeline and loads identity config.
module scale_rotate_translate_point_top #(
    parameter  int COORD_WIDTH = srt_pkg::COORD_WIDTH_DEF,
    localparam int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [srt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [srt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [DATA_W-1:0]              s_tdata,  // in_x, in_y, in_z
    input  logic [0:0]                     s_tuser,  // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [DATA_W-1:0]              m_tdata,  // out_x, out_y, out_z
    output logic [0:0]                     m_tuser   // saturated
);
    import srt_pkg::*;

    localparam int CW = COORD_WIDTH;

    xform_cfg_t              cfg_reg;
    logic [2:0][CW-1:0]      offset_reg;
    logic [NUM_STAGES-1:0]   valid_reg, valid_next;
    logic [NUM_STAGES:0]     stage_rdy;
    pipe_ctl_t               ctl;
    logic [2:0][CW-1:0]      in_coord, out_coord;
    logic                    out_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            cfg_reg.qw    <= QUAT_W_RESET;
            cfg_reg.qi    <= '0;
            cfg_reg.qj    <= '0;
            cfg_reg.qk    <= '0;
            cfg_reg.scale <= SCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_OFFSET_X: offset_reg[0]  <= cfg_wdata[CW-1:0];
                REG_OFFSET_Y: offset_reg[1]  <= cfg_wdata[CW-1:0];
                REG_OFFSET_Z: offset_reg[2]  <= cfg_wdata[CW-1:0];
                REG_QUAT_W:   cfg_reg.qw     <= cfg_wdata[Q_W-1:0];
                REG_QUAT_I:   cfg_reg.qi     <= cfg_wdata[Q_W-1:0];
                REG_QUAT_J:   cfg_reg.qj     <= cfg_wdata[Q_W-1:0];
                REG_QUAT_K:   cfg_reg.qk     <= cfg_wdata[Q_W-1:0];
                REG_SCALE:    cfg_reg.scale  <= cfg_wdata[SCALE_PACKED_W-1:0];
                default: ;
            endcase
        end
    end

    // ready ripples back from the output; a stage loads when empty or draining
    always_comb begin
        stage_rdy[NUM_STAGES] = m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_rdy[i]) begin
                valid_next[i] = (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en = stage_rdy[NUM_STAGES-1:0];

    assign in_coord[0] = s_tdata[CW-1:0];
    assign in_coord[1] = s_tdata[2*CW-1:CW];
    assign in_coord[2] = s_tdata[3*CW-1:2*CW];

    srt_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .ctl       (ctl),
        .xcfg      (cfg_reg),
        .offset    (offset_reg),
        .in_mode   (s_tuser[0]),
        .in_coord  (in_coord),
        .out_coord (out_coord),
        .out_sat   (out_sat)
    );

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = DATA_W'({out_coord[2], out_coord[1], out_coord[0]});
    assign m_tuser  = out_sat;

endmodule

// File: rtl/srt_checker.sv
// Port-level checker for the point transform block, bound to the top level.
`include "scale_rotate_translate_point_top_assert.svh"

module srt_checker #(
    parameter  int COORD_WIDTH = srt_pkg::COORD_WIDTH_DEF,
    localparam int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [DATA_W-1:0]              m_tdata,  // out_x, out_y, out_z
    input logic [0:0]                     m_tuser   // saturated
);
    localparam int CW = COORD_WIDTH;
    localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_C = ~MAX_C;

    logic x_lim, y_lim, z_lim;

    assign x_lim = (m_tdata[CW-1:0] == MAX_C) || (m_tdata[CW-1:0] == MIN_C);
    assign y_lim = (m_tdata[2*CW-1:CW] == MAX_C) || (m_tdata[2*CW-1:CW] == MIN_C);
    assign z_lim = (m_tdata[3*CW-1:2*CW] == MAX_C) || (m_tdata[3*CW-1:2*CW] == MIN_C);

    `SRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `SRT_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "result valid right after reset")
    `SRT_ASSERT_IMP(a_sat_at_limit, m_tvalid && m_tuser[0], x_lim || y_lim || z_lim, "saturated flag without a clipped component")
    `SRT_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while output stage empty")

endmodule

bind scale_rotate_translate_point_top srt_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_srt_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the scale, rotate and translate point block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    localparam int DATA_W        = ((3 * COORD_WIDTH_DEF + 7) / 8) * 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;

    localparam bit MODE_POINT  = 1'b0;
    localparam bit MODE_VECTOR = 1'b1;

    localparam logic [31:0] CRD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CRD_MIN = 32'h8000_0000;

    typedef logic signed [127:0] wide_t;

    localparam wide_t COORD_MAX = 128'sd2147483647;
    localparam wide_t COORD_MIN = -128'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } point_result_t;

    // quat[0] is w, then i, j, k
    typedef struct packed {
        logic [2:0][31:0] off;
        logic [3:0][15:0] quat;
        logic [47:0]      scale;
    } xform_t;

    class xform_tracker;
        logic signed [31:0] offset [3];
        logic signed [15:0] quat_w;
        logic signed [15:0] axis [3];
        logic signed [15:0] gain [3];
        point_result_t      due_points [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            for (int a = 0; a < 3; a++) begin
                offset[a] = '0;
                axis[a]   = '0;
                gain[a]   = SCALE_RESET[16*a +: 16];
            end
            quat_w       = QUAT_W_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_OFFSET_X: offset[0] = v[31:0];
                REG_OFFSET_Y: offset[1] = v[31:0];
                REG_OFFSET_Z: offset[2] = v[31:0];
                REG_QUAT_W:   quat_w    = v[15:0];
                REG_QUAT_I:   axis[0]   = v[15:0];
                REG_QUAT_J:   axis[1]   = v[15:0];
                REG_QUAT_K:   axis[2]   = v[15:0];
                REG_SCALE: begin
                    gain[0] = v[15:0];
                    gain[1] = v[31:16];
                    gain[2] = v[47:32];
                end
                default: ;
            endcase
        endfunction

        // Q2.14 product, round half up
        function wide_t round_q14(wide_t q, wide_t x);
            return (q * x + 8192) >>> 14;
        endfunction

        function point_result_t trs_transform(bit mode, logic [31:0] cx, cy, cz);
            wide_t            p [3];
            wide_t            s [3];
            wide_t            t [3];
            wide_t            r [3];
            wide_t            u [3];
            wide_t            w;
            logic [2:0][31:0] outv;
            point_result_t    res;
            int               b;
            int               c;
            p[0]    = $signed(cx);
            p[1]    = $signed(cy);
            p[2]    = $signed(cz);
            w       = quat_w;
            res.sat = 1'b0;
            for (int a = 0; a < 3; a++) begin
                s[a] = (p[a] * gain[a] + 128) >>> 8;
                u[a] = axis[a];
            end
            for (int a = 0; a < 3; a++) begin
                b    = (a + 1) % 3;
                c    = (a + 2) % 3;
                t[a] = 2 * (round_q14(u[b], s[c]) - round_q14(u[c], s[b]));
            end
            for (int a = 0; a < 3; a++) begin
                b    = (a + 1) % 3;
                c    = (a + 2) % 3;
                r[a] = s[a] + round_q14(w, t[a])
                       + (round_q14(u[b], t[c]) - round_q14(u[c], t[b]));
                if (mode == MODE_POINT) r[a] = r[a] + offset[a];
                if (r[a] > COORD_MAX) begin
                    r[a]    = COORD_MAX;
                    res.sat = 1'b1;
                end else if (r[a] < COORD_MIN) begin
                    r[a]    = COORD_MIN;
                    res.sat = 1'b1;
                end
                outv[a] = r[a][31:0];
            end
            res.x = outv[0];
            res.y = outv[1];
            res.z = outv[2];
            return res;
        endfunction

        function void note_point(bit mode, logic [31:0] cx, cy, cz);
            due_points.push_back(trs_transform(mode, cx, cy, cz));
        endfunction

        function int pending();
            return due_points.size();
        endfunction

        task flag_mismatch(string what);
            if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_point(logic [DATA_W-1:0] data, logic sat);
            point_result_t e;
            if (due_points.size() == 0) begin
                flag_mismatch($sformatf("result %h with no item pending", data));
                return;
            end
            e = due_points.pop_front();
            results_seen++;
            if (data[31:0] !== e.x)
                flag_mismatch($sformatf("result %0d out_x %h, want %h",
                                        results_seen, data[31:0], e.x));
            if (data[63:32] !== e.y)
                flag_mismatch($sformatf("result %0d out_y %h, want %h",
                                        results_seen, data[63:32], e.y));
            if (data[95:64] !== e.z)
                flag_mismatch($sformatf("result %0d out_z %h, want %h",
                                        results_seen, data[95:64], e.z));
            if (sat !== e.sat)
                flag_mismatch($sformatf("result %0d saturated %b, want %b",
                                        results_seen, sat, e.sat));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic [0:0]            m_tuser;

    xform_tracker sb;
    bit           hold_sink = 1'b0;

    scale_rotate_translate_point_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            v = 32'($urandom_range(0, 32'h0010_0000));
            if ($urandom_range(0, 1)) v = -v;
        end else if (sel < 6) begin
            v = 32'($urandom_range(0, 32'h0100_0000));
            if ($urandom_range(0, 1)) v = -v;
        end else if (sel < 9) begin
            v = $urandom();
        end else begin
            case ($urandom_range(0, 4))
                0:       v = CRD_MAX;
                1:       v = CRD_MIN;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h0000_0001;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [3:0][15:0] rand_quat();
        logic [3:0][15:0] q;
        real              a [4];
        real              norm;
        int unsigned      pick;
        pick = $urandom_range(0, 9);
        q    = '0;
        if (pick < 2) begin
            // not normalized, full range
            for (int i = 0; i < 4; i++) q[i] = 16'($urandom());
        end else if (pick < 3) begin
            q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
        end else begin
            norm = 0.0;
            for (int i = 0; i < 4; i++) begin
                a[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
                norm = norm + a[i] * a[i];
            end
            if (norm < 1.0e-4) begin
                q[0] = 16'h4000;
            end else begin
                norm = $sqrt(norm);
                for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(a[i] / norm * 16384.0));
            end
        end
        return q;
    endfunction

    function automatic xform_t rand_setting();
        xform_t      x;
        logic [15:0] g;
        int unsigned pick;
        for (int a = 0; a < 3; a++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)      x.off[a] = 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            else if (pick < 7) x.off[a] = $urandom();
            else               x.off[a] = '0;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                g = 16'($urandom_range(16'h0080, 16'h0300));
                if ($urandom_range(0, 1)) g = -g;
            end else if (pick < 8) begin
                g = 16'($urandom());
            end else begin
                g = 16'h0100;
            end
            x.scale[16*a +: 16] = g;
        end
        x.quat = rand_quat();
        return x;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    // junk above each offset and quaternion register's width must be dropped by the block
    task automatic load_setting(xform_t x);
        write_reg(REG_OFFSET_X, {16'($urandom()), x.off[0]});
        write_reg(REG_OFFSET_Y, {16'($urandom()), x.off[1]});
        write_reg(REG_OFFSET_Z, {16'($urandom()), x.off[2]});
        write_reg(REG_QUAT_W, {32'($urandom()), x.quat[0]});
        write_reg(REG_QUAT_I, {32'($urandom()), x.quat[1]});
        write_reg(REG_QUAT_J, {32'($urandom()), x.quat[2]});
        write_reg(REG_QUAT_K, {32'($urandom()), x.quat[3]});
        write_reg(REG_SCALE, x.scale);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_point(bit mode, logic [31:0] cx, cy, cz);
        s_tvalid <= 1'b1;
        s_tdata  <= {cz, cy, cx};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        sb.note_point(mode, cx, cy, cz);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic stream_points(int count, bit steady);
        int burst;
        burst = $urandom_range(0, 20);
        for (int n = 0; n < count; n++) begin
            offer_point($urandom_range(0, 1) ? MODE_VECTOR : MODE_POINT,
                        rand_coord(), rand_coord(), rand_coord());
            if (burst > 0 || steady) begin
                burst--;
            end else if (n < count - 1) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 20);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_point(m_tdata, m_tuser[0]);
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin : sink
        int style;
        int left;
        style = 0;
        left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 2);
                    left  = $urandom_range(10, 150);
                end
                left--;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        xform_t cfg;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity setting from reset
        offer_point(MODE_POINT, 32'h0, 32'h0, 32'h0);
        offer_point(MODE_POINT, CRD_MAX, CRD_MAX, CRD_MAX);
        offer_point(MODE_VECTOR, CRD_MIN, CRD_MIN, CRD_MIN);
        offer_point(MODE_POINT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
        offer_point(MODE_VECTOR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000);
        s_tvalid <= 1'b0;
        settle();

        // largest non-unit quaternion, largest scale and offsets: clipping
        cfg.off   = {3{CRD_MAX}};
        cfg.quat  = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        cfg.scale = {3{16'h7FFF}};
        load_setting(cfg);
        offer_point(MODE_POINT, 32'h0, 32'h0, 32'h0);
        offer_point(MODE_VECTOR, 32'h0, 32'h0, 32'h0);
        offer_point(MODE_POINT, CRD_MAX, CRD_MIN, CRD_MAX);
        offer_point(MODE_VECTOR, CRD_MIN, CRD_MAX, CRD_MIN);
        offer_point(MODE_POINT, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0001);
        s_tvalid <= 1'b0;
        settle();

        // quarter turn about z, most negative scale, lowest offsets
        cfg.off   = {3{CRD_MIN}};
        cfg.quat  = {16'd11585, 16'd0, 16'd0, 16'd11585};
        cfg.scale = {3{16'h8000}};
        load_setting(cfg);
        offer_point(MODE_POINT, 32'h0001_0000, 32'h0, 32'h0);
        offer_point(MODE_VECTOR, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        offer_point(MODE_POINT, CRD_MAX, CRD_MAX, CRD_MAX);
        offer_point(MODE_VECTOR, CRD_MIN, CRD_MIN, CRD_MIN);
        offer_point(MODE_POINT, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
        s_tvalid <= 1'b0;
        settle();

        // half turn about x, zero scale on one lane, mixed offsets
        cfg.off   = {32'h0001_8000, 32'hFFFF_0000, 32'h0000_0001};
        cfg.quat  = {16'h0000, 16'h0000, 16'h4000, 16'h0000};
        cfg.scale = {16'h0100, 16'h0000, 16'hFF00};
        load_setting(cfg);
        offer_point(MODE_POINT, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        offer_point(MODE_VECTOR, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        offer_point(MODE_POINT, CRD_MIN, CRD_MAX, CRD_MIN);
        s_tvalid <= 1'b0;
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            load_setting(rand_setting());
            if (phase == 3) begin
                // long receiver hold-off while the sender keeps offering
                hold_sink = 1'b1;
                stream_points(60, 1'b1);
                @(posedge aclk);
                stream_points(100, 1'b0);
            end else begin
                stream_points(160, 1'b0);
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
